FILE: sv/crd_pkg.sv
// Package for the camera ray direction block: widths, register map, reset
// values and the structs shared between the pipeline modules.
// Depends on nothing; every other file of the block uses it.
package crd_pkg;

  // Fixed field widths.
  localparam int unsigned PIX_W  = 12;
  localparam int unsigned DIM_W  = 13;
  localparam int unsigned DIST_W = 16;
  localparam int unsigned COMP_W = 16;
  localparam int unsigned VEC_W  = 3 * COMP_W;
  localparam int unsigned RAY_W  = 16;

  // Configuration port.
  localparam int unsigned ADDR_W = 6;
  localparam int unsigned DATA_W = 64;

  // Screen width in Q8.8.
  localparam int unsigned SCREEN_WIDTH_Q8 = 512;

  // Internal widths of the datapath.
  localparam int unsigned OFF_W  = DIM_W + 2;          // w - 2x, h - 2y
  localparam int unsigned WD_W   = DIM_W + DIST_W;     // w * d
  localparam int unsigned PR_W   = OFF_W + COMP_W;     // offset * component
  localparam int unsigned PF_W   = WD_W + 1 + COMP_W;  // w * d * component
  localparam int unsigned SRU_W  = PR_W + 1;
  localparam int unsigned V_W    = 49;                 // unnormalized component
  localparam int unsigned MAG_W  = V_W - 1;
  localparam int unsigned NM_W   = 30;                 // magnitude after scaling
  localparam int unsigned SH_W   = $clog2(MAG_W - NM_W + 1);
  localparam int unsigned SQ1_W  = 2 * NM_W;
  localparam int unsigned SQ_W   = SQ1_W + 2;
  localparam int unsigned RES_W  = SQ_W + 1;
  localparam int unsigned ROOT_W = 32;
  localparam int unsigned Q_W    = RAY_W + 1;
  localparam int unsigned DEN_W  = ROOT_W + 1;
  localparam int unsigned REM_W  = NM_W + RAY_W + 2;
  localparam int unsigned CMP_W  = DEN_W + Q_W;

  // Stage counts.
  localparam int unsigned VEC_STAGES  = 8;
  localparam int unsigned SQRT_STAGES = (SQ_W + 1) / 2;
  localparam int unsigned DIV_STAGES  = Q_W + 2;

  // Register map: index is byte address divided by eight.
  typedef enum logic [2:0] {
    REG_RIGHT   = 3'd0,
    REG_UP      = 3'd1,
    REG_FORWARD = 3'd2,
    REG_DIST    = 3'd3,
    REG_WIDTH   = 3'd4,
    REG_HEIGHT  = 3'd5
  } reg_index_t;

  localparam logic [VEC_W-1:0]  RIGHT_RESET   = 48'h0000_0000_7FFF;
  localparam logic [VEC_W-1:0]  UP_RESET      = 48'h0000_7FFF_0000;
  localparam logic [VEC_W-1:0]  FORWARD_RESET = 48'h7FFF_0000_0000;
  localparam logic [DIST_W-1:0] DIST_RESET    = 16'd256;
  localparam logic [DIM_W-1:0]  WIDTH_RESET   = 13'd640;
  localparam logic [DIM_W-1:0]  HEIGHT_RESET  = 13'd480;

  // Camera set-up as held by the register file.
  typedef struct packed {
    logic [VEC_W-1:0]  right_vector;
    logic [VEC_W-1:0]  up_vector;
    logic [VEC_W-1:0]  forward_vector;
    logic [DIST_W-1:0] screen_distance;
    logic [DIM_W-1:0]  image_width;
    logic [DIM_W-1:0]  image_height;
  } cam_cfg_t;

  // Stall control handed to each pipeline section.
  typedef struct packed {
    logic en;        // the output register moves or is empty
    logic take_out;  // the next section's first stage takes a word
  } pipe_ctrl_t;

  // Scaled magnitudes, signs and the zero flag of one ray.
  typedef struct packed {
    logic [2:0][NM_W-1:0] mag;
    logic [2:0]           neg;
    logic                 degen;
  } norm_t;

endpackage

FILE: sv/crd_pixel_if.sv
// Channel that carries pixel coordinates into the block.
// Depends on crd_pkg for the field widths.
interface crd_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [crd_pkg::PIX_W-1:0]   pixel_x;
  logic [crd_pkg::PIX_W-1:0]   pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

FILE: sv/crd_ray_if.sv
// Channel that carries unit ray directions out of the block.
// Depends on crd_pkg for the field widths.
interface crd_ray_if;
  logic                               valid;
  logic                               ready;
  logic signed [crd_pkg::RAY_W-1:0]   ray_x;
  logic signed [crd_pkg::RAY_W-1:0]   ray_y;
  logic signed [crd_pkg::RAY_W-1:0]   ray_z;
  logic                               degenerate;

  modport source (output valid, output ray_x, output ray_y, output ray_z,
                  output degenerate, input ready);
  modport sink (input valid, input ray_x, input ray_y, input ray_z,
                input degenerate, output ready);
endinterface

FILE: sv/crd_regs.sv
// APB-style register file that holds the camera set-up.
// Depends on crd_pkg for the register map and reset values.
module crd_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [crd_pkg::ADDR_W-1:0]  paddr,
  input  logic [crd_pkg::DATA_W-1:0]  pwdata,
  output logic [crd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output crd_pkg::cam_cfg_t           cfg
);

  crd_pkg::reg_index_t idx;

  assign idx    = crd_pkg::reg_index_t'(paddr[crd_pkg::ADDR_W-1:3]);
  assign pready = 1'b1;

  // Register writes complete in the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.right_vector    <= crd_pkg::RIGHT_RESET;
      cfg.up_vector       <= crd_pkg::UP_RESET;
      cfg.forward_vector  <= crd_pkg::FORWARD_RESET;
      cfg.screen_distance <= crd_pkg::DIST_RESET;
      cfg.image_width     <= crd_pkg::WIDTH_RESET;
      cfg.image_height    <= crd_pkg::HEIGHT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        crd_pkg::REG_RIGHT:   cfg.right_vector    <= pwdata[crd_pkg::VEC_W-1:0];
        crd_pkg::REG_UP:      cfg.up_vector       <= pwdata[crd_pkg::VEC_W-1:0];
        crd_pkg::REG_FORWARD: cfg.forward_vector  <= pwdata[crd_pkg::VEC_W-1:0];
        crd_pkg::REG_DIST:    cfg.screen_distance <= pwdata[crd_pkg::DIST_W-1:0];
        crd_pkg::REG_WIDTH:   cfg.image_width     <= pwdata[crd_pkg::DIM_W-1:0];
        crd_pkg::REG_HEIGHT:  cfg.image_height    <= pwdata[crd_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data, zero extended.
  always_comb begin
    unique case (idx)
      crd_pkg::REG_RIGHT:   prdata = crd_pkg::DATA_W'(cfg.right_vector);
      crd_pkg::REG_UP:      prdata = crd_pkg::DATA_W'(cfg.up_vector);
      crd_pkg::REG_FORWARD: prdata = crd_pkg::DATA_W'(cfg.forward_vector);
      crd_pkg::REG_DIST:    prdata = crd_pkg::DATA_W'(cfg.screen_distance);
      crd_pkg::REG_WIDTH:   prdata = crd_pkg::DATA_W'(cfg.image_width);
      crd_pkg::REG_HEIGHT:  prdata = crd_pkg::DATA_W'(cfg.image_height);
      default:              prdata = '0;
    endcase
  end

endmodule

FILE: sv/crd_vec.sv
// Front section: screen offsets, basis products, unnormalized direction,
// magnitude scaling and sum of squares, eight register stages.
// Depends on crd_pkg.
module crd_vec (
  input  logic                          clk,
  input  logic                          rst,
  input  crd_pkg::pipe_ctrl_t           ctrl,
  input  crd_pkg::cam_cfg_t             cfg,
  input  logic                          in_valid,
  input  logic [crd_pkg::PIX_W-1:0]     pixel_x,
  input  logic [crd_pkg::PIX_W-1:0]     pixel_y,
  output logic                          in_take,
  output logic                          out_valid,
  output crd_pkg::norm_t                out_norm,
  output logic [crd_pkg::SQ_W-1:0]      out_sum
);

  localparam int unsigned N = crd_pkg::VEC_STAGES;
  localparam logic signed [17:0] SW_S = 18'(crd_pkg::SCREEN_WIDTH_Q8);

  logic [N-1:0] vld;
  logic [N-1:0] vin;
  logic [N:0]   take;

  // Stage handshake: a stage loads when the pipe moves or it is empty, and
  // drops its word when the next stage took it without a refill.
  always_comb begin
    vin  = {vld[N-2:0], in_valid};
    take = {ctrl.take_out, {N{ctrl.en}} | ~vld};
  end

  assign in_take   = take[0];
  assign out_valid = vld[N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (take[k]) begin
          vld[k] <= vin[k];
        end else if (take[k+1]) begin
          vld[k] <= 1'b0;
        end
      end
    end
  end

  // Stage 0: screen offsets and width times distance.
  logic [crd_pkg::DIM_W-1:0]          w_eff, h_eff;
  logic signed [crd_pkg::OFF_W-1:0]   nx_n, dy_n, nx0, dy0;
  logic [crd_pkg::WD_W-1:0]           wd_n, wd0;

  always_comb begin
    w_eff = (cfg.image_width == '0) ? crd_pkg::DIM_W'(1) : cfg.image_width;
    h_eff = (cfg.image_height == '0) ? crd_pkg::DIM_W'(1) : cfg.image_height;
    nx_n  = $signed({2'b00, w_eff}) - $signed({2'b00, pixel_x, 1'b0});
    dy_n  = $signed({2'b00, h_eff}) - $signed({2'b00, pixel_y, 1'b0});
    wd_n  = w_eff * cfg.screen_distance;
  end

  always_ff @(posedge clk) begin
    if (take[0]) begin
      nx0 <= nx_n;
      dy0 <= dy_n;
      wd0 <= wd_n;
    end
  end

  // Stage 1: products with the basis components.
  logic signed [crd_pkg::COMP_W-1:0]  rc, uc, fc;
  logic signed [crd_pkg::PR_W-1:0]    pr_n [3];
  logic signed [crd_pkg::PR_W-1:0]    pu_n [3];
  logic signed [crd_pkg::PF_W-1:0]    pf_n [3];
  logic signed [crd_pkg::PR_W-1:0]    pr1 [3];
  logic signed [crd_pkg::PR_W-1:0]    pu1 [3];
  logic signed [crd_pkg::PF_W-1:0]    pf1 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rc = $signed(cfg.right_vector[crd_pkg::COMP_W*i +: crd_pkg::COMP_W]);
      uc = $signed(cfg.up_vector[crd_pkg::COMP_W*i +: crd_pkg::COMP_W]);
      fc = $signed(cfg.forward_vector[crd_pkg::COMP_W*i +: crd_pkg::COMP_W]);
      pr_n[i] = nx0 * rc;
      pu_n[i] = dy0 * uc;
      pf_n[i] = $signed({1'b0, wd0}) * fc;
    end
  end

  always_ff @(posedge clk) begin
    if (take[1]) begin
      pr1 <= pr_n;
      pu1 <= pu_n;
      pf1 <= pf_n;
    end
  end

  // Stage 2: the scaled direction components.
  logic signed [crd_pkg::SRU_W-1:0]   sru;
  logic signed [crd_pkg::V_W-1:0]     va, vb;
  logic signed [crd_pkg::V_W-1:0]     v_n [3];
  logic signed [crd_pkg::V_W-1:0]     v2 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sru    = pr1[i] + pu1[i];
      va     = sru * SW_S;
      vb     = $signed({pf1[i], 1'b0});
      v_n[i] = va + vb;
    end
  end

  always_ff @(posedge clk) begin
    if (take[2]) begin
      v2 <= v_n;
    end
  end

  // Stage 3: sign and magnitude.
  logic [crd_pkg::MAG_W-1:0]  mag_n [3];
  logic [2:0]                 neg_n;
  logic [crd_pkg::MAG_W-1:0]  mag3 [3];
  logic [2:0]                 neg3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_n[i] = v2[i][crd_pkg::V_W-1];
      mag_n[i] = neg_n[i] ? crd_pkg::MAG_W'(-v2[i]) : crd_pkg::MAG_W'(v2[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (take[3]) begin
      mag3 <= mag_n;
      neg3 <= neg_n;
    end
  end

  // Stage 4: right shift that brings the largest magnitude under 2^30.
  logic [crd_pkg::MAG_W-1:0]  orv;
  logic [crd_pkg::SH_W-1:0]   s_n, s4;
  logic [crd_pkg::MAG_W-1:0]  mag4 [3];
  logic [2:0]                 neg4;
  logic                       degen4;

  always_comb begin
    orv = mag3[0] | mag3[1] | mag3[2];
    s_n = '0;
    for (int j = crd_pkg::NM_W; j < crd_pkg::MAG_W; j++) begin
      if (orv[j]) begin
        s_n = crd_pkg::SH_W'(j - crd_pkg::NM_W + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take[4]) begin
      mag4   <= mag3;
      neg4   <= neg3;
      s4     <= s_n;
      degen4 <= (orv == '0);
    end
  end

  // Stage 5: scaled magnitudes.
  logic [crd_pkg::NM_W-1:0]   m_n [3];
  logic [crd_pkg::NM_W-1:0]   m5 [3];
  logic [2:0]                 neg5;
  logic                       degen5;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_n[i] = crd_pkg::NM_W'(mag4[i] >> s4);
    end
  end

  always_ff @(posedge clk) begin
    if (take[5]) begin
      m5     <= m_n;
      neg5   <= neg4;
      degen5 <= degen4;
    end
  end

  // Stage 6: squares.
  logic [crd_pkg::SQ1_W-1:0]  sq_n [3];
  logic [crd_pkg::SQ1_W-1:0]  sq6 [3];
  logic [crd_pkg::NM_W-1:0]   m6 [3];
  logic [2:0]                 neg6;
  logic                       degen6;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_n[i] = m5[i] * m5[i];
    end
  end

  always_ff @(posedge clk) begin
    if (take[6]) begin
      sq6    <= sq_n;
      m6     <= m5;
      neg6   <= neg5;
      degen6 <= degen5;
    end
  end

  // Stage 7: sum of squares.
  logic [crd_pkg::SQ_W-1:0]   sum_n;

  assign sum_n = crd_pkg::SQ_W'(sq6[0]) + crd_pkg::SQ_W'(sq6[1])
               + crd_pkg::SQ_W'(sq6[2]);

  always_ff @(posedge clk) begin
    if (take[7]) begin
      out_sum        <= sum_n;
      out_norm.degen <= degen6;
      out_norm.neg   <= neg6;
      for (int i = 0; i < 3; i++) begin
        out_norm.mag[i] <= m6[i];
      end
    end
  end

endmodule

FILE: sv/crd_sqrt.sv
// Integer square root of the sum of squares, one result bit per stage.
// Depends on crd_pkg.
module crd_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  crd_pkg::pipe_ctrl_t           ctrl,
  input  logic                          in_valid,
  input  crd_pkg::norm_t                in_norm,
  input  logic [crd_pkg::SQ_W-1:0]      in_sum,
  output logic                          in_take,
  output logic                          out_valid,
  output crd_pkg::norm_t                out_norm,
  output logic [crd_pkg::ROOT_W-1:0]    out_root
);

  localparam int unsigned N = crd_pkg::SQRT_STAGES;
  localparam int unsigned W = crd_pkg::RES_W;

  logic [N-1:0] vld;
  logic [N-1:0] vin;
  logic [N:0]   take;

  // Stage handshake, as in the front section.
  always_comb begin
    vin  = {vld[N-2:0], in_valid};
    take = {ctrl.take_out, {N{ctrl.en}} | ~vld};
  end

  assign in_take   = take[0];
  assign out_valid = vld[N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (take[k]) begin
          vld[k] <= vin[k];
        end else if (take[k+1]) begin
          vld[k] <= 1'b0;
        end
      end
    end
  end

  logic [W-1:0]     rem [N];
  logic [W-1:0]     res [N];
  crd_pkg::norm_t   nd  [N];

  // Each stage tries one bit of the root, from the top bit down.
  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [W-1:0] BITV = W'(1) << (2 * (N - 1 - k));
    logic [W-1:0]   rem_p, res_p, trial;
    crd_pkg::norm_t nd_p;

    if (k == 0) begin : g_first
      assign rem_p = W'(in_sum);
      assign res_p = '0;
      assign nd_p  = in_norm;
    end else begin : g_next
      assign rem_p = rem[k-1];
      assign res_p = res[k-1];
      assign nd_p  = nd[k-1];
    end

    assign trial = res_p + BITV;

    always_ff @(posedge clk) begin
      if (take[k]) begin
        nd[k] <= nd_p;
        if (rem_p >= trial) begin
          rem[k] <= rem_p - trial;
          res[k] <= (res_p >> 1) + BITV;
        end else begin
          rem[k] <= rem_p;
          res[k] <= res_p >> 1;
        end
      end
    end
  end

  assign out_norm = nd[N-1];
  assign out_root = res[N-1][crd_pkg::ROOT_W-1:0];

endmodule

FILE: sv/crd_div.sv
// Divides each scaled magnitude by the length with rounding, one quotient
// bit per stage, then applies sign and saturation into the output register.
// Depends on crd_pkg.
module crd_div (
  input  logic                              clk,
  input  logic                              rst,
  input  crd_pkg::pipe_ctrl_t               ctrl,
  input  logic                              in_valid,
  input  crd_pkg::norm_t                    in_norm,
  input  logic [crd_pkg::ROOT_W-1:0]        in_root,
  output logic                              in_take,
  output logic                              out_valid,
  output logic signed [crd_pkg::RAY_W-1:0]  ray_x,
  output logic signed [crd_pkg::RAY_W-1:0]  ray_y,
  output logic signed [crd_pkg::RAY_W-1:0]  ray_z,
  output logic                              degenerate
);

  localparam int unsigned N  = crd_pkg::DIV_STAGES;
  localparam int unsigned NB = crd_pkg::Q_W;
  localparam logic [crd_pkg::Q_W-1:0] QPOS = crd_pkg::Q_W'((1 << (crd_pkg::RAY_W - 1)) - 1);
  localparam logic [crd_pkg::Q_W-1:0] QNEG = crd_pkg::Q_W'(1 << (crd_pkg::RAY_W - 1));

  logic [N-1:0] vld;
  logic [N-1:0] vin;
  logic [N:0]   take;

  // Stage handshake, as in the front section.
  always_comb begin
    vin  = {vld[N-2:0], in_valid};
    take = {ctrl.take_out, {N{ctrl.en}} | ~vld};
  end

  assign in_take   = take[0];
  assign out_valid = vld[N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (take[k]) begin
          vld[k] <= vin[k];
        end else if (take[k+1]) begin
          vld[k] <= 1'b0;
        end
      end
    end
  end

  // Set-up stage: divisor 2L and numerators m*65536 + L.
  logic [crd_pkg::ROOT_W-1:0]   len;
  logic [crd_pkg::DEN_W-1:0]    den0;
  logic [crd_pkg::REM_W-1:0]    num0 [3];
  crd_pkg::norm_t               nd0;

  assign len = (in_root == '0) ? crd_pkg::ROOT_W'(1) : in_root;

  always_ff @(posedge clk) begin
    if (take[0]) begin
      den0 <= {len, 1'b0};
      nd0  <= in_norm;
      for (int i = 0; i < 3; i++) begin
        num0[i] <= crd_pkg::REM_W'({in_norm.mag[i], {crd_pkg::RAY_W{1'b0}}})
                 + crd_pkg::REM_W'(len);
      end
    end
  end

  // Restoring division stages, top quotient bit first.
  logic [crd_pkg::DEN_W-1:0]    den [NB];
  logic [crd_pkg::REM_W-1:0]    rem [NB][3];
  logic [crd_pkg::Q_W-1:0]      quo [NB][3];
  crd_pkg::norm_t               nd  [NB];

  for (genvar k = 0; k < NB; k++) begin : g_bit
    localparam int unsigned SH = NB - 1 - k;
    logic [crd_pkg::DEN_W-1:0]  den_p;
    logic [crd_pkg::REM_W-1:0]  rem_p [3];
    logic [crd_pkg::Q_W-1:0]    quo_p [3];
    crd_pkg::norm_t             nd_p;
    logic [crd_pkg::CMP_W-1:0]  dsh;

    if (k == 0) begin : g_first
      assign den_p = den0;
      assign nd_p  = nd0;
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_p[i] = num0[i];
        assign quo_p[i] = '0;
      end
    end else begin : g_next
      assign den_p = den[k-1];
      assign nd_p  = nd[k-1];
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_p[i] = rem[k-1][i];
        assign quo_p[i] = quo[k-1][i];
      end
    end

    assign dsh = crd_pkg::CMP_W'(den_p) << SH;

    always_ff @(posedge clk) begin
      if (take[k+1]) begin
        den[k] <= den_p;
        nd[k]  <= nd_p;
        for (int i = 0; i < 3; i++) begin
          if (crd_pkg::CMP_W'(rem_p[i]) >= dsh) begin
            rem[k][i] <= crd_pkg::REM_W'(crd_pkg::CMP_W'(rem_p[i]) - dsh);
            quo[k][i] <= quo_p[i] | (crd_pkg::Q_W'(1) << SH);
          end else begin
            rem[k][i] <= rem_p[i];
            quo[k][i] <= quo_p[i];
          end
        end
      end
    end
  end

  // Output stage: saturation, sign and the zero-length case.
  logic signed [crd_pkg::RAY_W-1:0] r_n [3];
  logic [crd_pkg::Q_W-1:0]          qs;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (nd[NB-1].degen) begin
        qs     = '0;
        r_n[i] = '0;
      end else if (nd[NB-1].neg[i]) begin
        qs     = (quo[NB-1][i] > QNEG) ? QNEG : quo[NB-1][i];
        r_n[i] = crd_pkg::RAY_W'(-qs);
      end else begin
        qs     = (quo[NB-1][i] > QPOS) ? QPOS : quo[NB-1][i];
        r_n[i] = crd_pkg::RAY_W'(qs);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take[N-1]) begin
      ray_x      <= r_n[0];
      ray_y      <= r_n[1];
      ray_z      <= r_n[2];
      degenerate <= nd[NB-1].degen;
    end
  end

endmodule

FILE: sv/camera_ray_direction.sv
// Pinhole camera ray generation: pixel coordinate in, unit ray direction out.
//
// The pixel channel takes a column and a row; the ray channel gives ray_x,
// ray_y and ray_z in signed Q1.15 and a degenerate flag, set with all three
// components zero when the unnormalized direction has zero length. Basis
// vectors, screen distance and image size are written over the APB-style
// port at byte address 8*i; write them only while no word is in flight.
//
// From a pixel word's acceptance to its ray word in the output register,
// 8 stages form the direction and its sum of squares, 31 stages take the
// square root one bit each, and 19 stages do set-up, a 17-bit divide one
// bit each and the sign and saturation.
// Throughput is one word per clock while the receiver keeps ready high.
//
// When the receiver holds ready low, the pipeline keeps its words; empty
// stages still close up, so pixel words are taken until the pipeline is
// full, and nothing is lost or repeated. Reset empties the pipeline and
// restores the default camera: right along x, up along y, forward along z,
// distance 1.0 and a 640 by 480 image.
module camera_ray_direction (
  input  logic                        clk,
  input  logic                        rst,
  crd_pixel_if.sink                   pixel,
  crd_ray_if.source                   ray,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [crd_pkg::ADDR_W-1:0]  paddr,
  input  logic [crd_pkg::DATA_W-1:0]  pwdata,
  output logic [crd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  crd_pkg::cam_cfg_t      cfg;
  crd_pkg::pipe_ctrl_t    vec_ctrl, sqrt_ctrl, div_ctrl;
  logic                   en;
  logic                   vec_valid, sqrt_valid, div_take, sqrt_take;
  crd_pkg::norm_t         vec_norm, sqrt_norm;
  logic [crd_pkg::SQ_W-1:0]   vec_sum;
  logic [crd_pkg::ROOT_W-1:0] sqrt_root;

  // Register file.
  crd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The whole pipe moves when the output register is free or being taken.
  assign en        = !ray.valid || ray.ready;
  assign vec_ctrl  = '{en: en, take_out: sqrt_take};
  assign sqrt_ctrl = '{en: en, take_out: div_take};
  assign div_ctrl  = '{en: en, take_out: ray.ready};

  crd_vec u_vec (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (vec_ctrl),
    .cfg       (cfg),
    .in_valid  (pixel.valid),
    .pixel_x   (pixel.pixel_x),
    .pixel_y   (pixel.pixel_y),
    .in_take   (pixel.ready),
    .out_valid (vec_valid),
    .out_norm  (vec_norm),
    .out_sum   (vec_sum)
  );

  crd_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (sqrt_ctrl),
    .in_valid  (vec_valid),
    .in_norm   (vec_norm),
    .in_sum    (vec_sum),
    .in_take   (sqrt_take),
    .out_valid (sqrt_valid),
    .out_norm  (sqrt_norm),
    .out_root  (sqrt_root)
  );

  crd_div u_div (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (div_ctrl),
    .in_valid   (sqrt_valid),
    .in_norm    (sqrt_norm),
    .in_root    (sqrt_root),
    .in_take    (div_take),
    .out_valid  (ray.valid),
    .ray_x      (ray.ray_x),
    .ray_y      (ray.ray_y),
    .ray_z      (ray.ray_z),
    .degenerate (ray.degenerate)
  );

endmodule
